// File: src/kld_pkg.sv
package kld_pkg;

    localparam int KEY_ROWS    = 4;
    localparam int KEY_COLUMNS = 10;
    localparam int KEY_ENTRIES = KEY_ROWS * KEY_COLUMNS;
    localparam int ADDR_W      = $clog2(KEY_ENTRIES);
    localparam int CODE_W      = 7;
    localparam int DUTY_W      = 8;

    localparam logic [1:0] SHIFT_ROW  = 2'd2;
    localparam logic [3:0] SHIFT_COL  = 4'd0;
    localparam logic [1:0] SYMBOL_ROW = 2'd3;
    localparam logic [3:0] SYMBOL_COL = 4'd8;

    localparam logic [DUTY_W-1:0] DUTY_FULL = '1;

    localparam logic [CODE_W-1:0] KC_NONE  = 7'h00;
    localparam logic [CODE_W-1:0] KC_BKSP  = 7'h08;
    localparam logic [CODE_W-1:0] KC_NEXT  = 7'h09;
    localparam logic [CODE_W-1:0] KC_ENTER = 7'h0A;
    localparam logic [CODE_W-1:0] KC_PREV  = 7'h0B;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_IGNORE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic col_ok;
        logic is_shift;
        logic is_symbol;
    } key_ctl_t;

endpackage

// File: src/keypad_layer_decoder.sv
// Keypad layer decoder.
// Input channel (in_valid/in_stall): one key event per item, carrying
// operation (press, release, fade tick, ignore), key_row and the raw key_column.
// Output channel (out_valid/out_stall): exactly one item per input item,
// carrying char_valid, char_code and backlight_level after that event.
// out_valid rises once the accepted item has passed both registers: the
// keymap ROM is read at the accepting edge, and the modifier and backlight
// update loads the output register once it is free. Throughput is one item
// per cycle while the receiver does not stall.
// Reset clears shift, symbol and caps lock, arms the caps toggle and sets
// the backlight to 0; both pipeline stages come up empty.
// While the receiver stalls, the output item holds; one further item can
// be taken into the lookup stage, after which in_stall rises until the
// output register is taken.
module keypad_layer_decoder
    import kld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [1:0]        key_row,
    input  logic [3:0]        key_column,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              char_valid,
    output logic [CODE_W-1:0] char_code,
    output logic [DUTY_W-1:0] backlight_level
);

    logic              s1_valid_reg;
    key_ctl_t          s1_ctl_reg;
    key_ctl_t          in_ctl;
    logic              out_valid_reg;
    logic              char_valid_reg;
    logic [CODE_W-1:0] char_code_reg;

    logic              shift_reg, shift_next;
    logic              symbol_reg, symbol_next;
    logic              caps_reg, caps_next;
    logic              armed_reg, armed_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              char_valid_next;
    logic [CODE_W-1:0] char_code_next;

    logic              s2_free;
    logic              s1_move;
    logic              s1_load;
    logic [3:0]        vcol;
    logic [ADDR_W-1:0] rom_addr;
    logic [CODE_W-1:0] lower_code;
    logic [CODE_W-1:0] upper_code;
    logic [CODE_W-1:0] symbol_code;
    logic [CODE_W-1:0] pick_code;

    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign s1_load  = in_valid && !in_stall;

    // columns are wired in reverse on the matrix
    always_comb
    begin
        in_ctl.op     = op_t'(operation);
        in_ctl.col_ok = key_column < 4'(KEY_COLUMNS);
        vcol          = in_ctl.col_ok ? 4'(KEY_COLUMNS - 1) - key_column : 4'd0;
        in_ctl.is_shift  = in_ctl.col_ok && key_row == SHIFT_ROW && vcol == SHIFT_COL;
        in_ctl.is_symbol = in_ctl.col_ok && key_row == SYMBOL_ROW && vcol == SYMBOL_COL;
        rom_addr = ADDR_W'(key_row) * ADDR_W'(KEY_COLUMNS) + ADDR_W'(vcol);
    end

    kld_keymap_rom u_rom (
        .clk         (clk),
        .rd_en       (s1_load),
        .addr        (rom_addr),
        .lower_code  (lower_code),
        .upper_code  (upper_code),
        .symbol_code (symbol_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_ctl_reg <= in_ctl;
        end
    end

    always_comb
    begin
        shift_next      = shift_reg;
        symbol_next     = symbol_reg;
        caps_next       = caps_reg;
        armed_next      = armed_reg;
        duty_next       = duty_reg;
        char_valid_next = 1'b0;
        char_code_next  = KC_NONE;

        if (symbol_reg)
            pick_code = symbol_code;
        else if (shift_reg || caps_reg)
            pick_code = upper_code;
        else
            pick_code = lower_code;

        case (s1_ctl_reg.op)
            OP_PRESS:
            begin
                if (s1_ctl_reg.is_shift)
                    shift_next = 1'b1;
                else if (s1_ctl_reg.is_symbol)
                    symbol_next = 1'b1;
                else if (s1_ctl_reg.col_ok && pick_code != KC_NONE)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = pick_code;
                end
                if (symbol_next && shift_next && armed_reg)
                begin
                    caps_next  = !caps_reg;
                    armed_next = 1'b0;
                end
                if (!symbol_next && !shift_next)
                    armed_next = 1'b1;
                duty_next = DUTY_FULL;
            end
            OP_RELEASE:
            begin
                if (s1_ctl_reg.is_shift)
                    shift_next = 1'b0;
                if (s1_ctl_reg.is_symbol)
                    symbol_next = 1'b0;
                if (!symbol_next && !shift_next)
                    armed_next = 1'b1;
            end
            OP_TICK:
            begin
                if (duty_reg != '0)
                    duty_next = duty_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 1'b0;
            symbol_reg    <= 1'b0;
            caps_reg      <= 1'b0;
            armed_reg     <= 1'b1;
            duty_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                shift_reg     <= shift_next;
                symbol_reg    <= symbol_next;
                caps_reg      <= caps_next;
                armed_reg     <= armed_next;
                duty_reg      <= duty_next;
                out_valid_reg <= 1'b1;
            end
            else if (s2_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            char_valid_reg <= char_valid_next;
            char_code_reg  <= char_code_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign char_valid      = char_valid_reg;
    assign char_code       = char_code_reg;
    assign backlight_level = duty_reg;

endmodule

// File: src/kld_keymap_rom.sv
module kld_keymap_rom
    import kld_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    output logic [CODE_W-1:0] lower_code,
    output logic [CODE_W-1:0] upper_code,
    output logic [CODE_W-1:0] symbol_code
);

    localparam logic [CODE_W-1:0] LOWER_MAP [KEY_ENTRIES] = '{
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, KC_BKSP,
        KC_NONE, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h24, KC_ENTER,
        KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_PREV, 7'h30, 7'h20, KC_NONE,
        KC_NEXT
    };

    localparam logic [CODE_W-1:0] UPPER_MAP [KEY_ENTRIES] = '{
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, KC_BKSP,
        KC_NONE, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h24, KC_ENTER,
        KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_PREV, 7'h30, 7'h20, KC_NONE,
        KC_NEXT
    };

    localparam logic [CODE_W-1:0] SYMBOL_MAP [KEY_ENTRIES] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h40, 7'h23, 7'h2B, 7'h2D, 7'h2A, 7'h2F, 7'h28, 7'h29, 7'h5F, KC_BKSP,
        KC_NONE, 7'h21, 7'h3F, 7'h3B, 7'h3A, 7'h27, 7'h22, 7'h2C, 7'h2E, KC_ENTER,
        KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_NONE, KC_PREV, 7'h30, 7'h20, KC_NONE,
        KC_NEXT
    };

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (addr < ADDR_W'(KEY_ENTRIES))
            begin
                lower_code  <= LOWER_MAP[addr];
                upper_code  <= UPPER_MAP[addr];
                symbol_code <= SYMBOL_MAP[addr];
            end
            else
            begin
                lower_code  <= KC_NONE;
                upper_code  <= KC_NONE;
                symbol_code <= KC_NONE;
            end
        end
    end

endmodule
